// ===== sv/lpfcrc_pkg.sv =====
// package: types, constants and crc function for the length-prefixed frame checker
`timescale 1ns / 1ps

package lpfcrc_pkg;

    localparam int MAX_FRAME = 255;
    localparam int MIN_LEN = 4;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OUT_PAYLOAD = 2'd0,
        OUT_OK      = 2'd1,
        OUT_BAD_CRC = 2'd2,
        OUT_ABORTED = 2'd3
    } out_kind_t;

    typedef enum logic {
        IN_RX_BYTE = 1'b0,
        IN_TIMEOUT = 1'b1
    } in_kind_t;

    typedef enum logic {
        ST_HUNT  = 1'b0,
        ST_FRAME = 1'b1
    } front_state_t;

    typedef struct packed {
        out_kind_t  kind;
        logic [7:0] data;
    } lpfcrc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lpfcrc_qstat_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== sv/lpfcrc_if.sv =====
// interfaces: input and output beat channels of the frame checker
`timescale 1ns / 1ps

interface lpfcrc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface lpfcrc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] payload_byte;
    logic       frame_end;

    modport source (output valid, output out_kind, output payload_byte, output frame_end,
                    input ready);
    modport sink (input valid, input out_kind, input payload_byte, input frame_end,
                  output ready);
endinterface

// ===== sv/lpfcrc_front.sv =====
// front: frame tracking, crc update and classification of input beats
`timescale 1ns / 1ps

module lpfcrc_front
    import lpfcrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_kind,
    input  logic [7:0]    in_byte,
    input  lpfcrc_qstat_t qstat,
    output logic          push,
    output lpfcrc_item_t  push_item
);

    front_state_t state_reg, state_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   pos_reg, pos_next;
    logic [15:0]  crc_reg, crc_next;
    logic [7:0]   low_reg, low_next;

    logic         accept;
    logic [8:0]   pos_ext;
    logic [8:0]   len_ext;
    logic [8:0]   byte_ext;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign pos_ext  = {1'b0, pos_reg};
    assign len_ext  = {1'b0, len_reg};
    assign byte_ext = {1'b0, in_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            len_reg   <= 8'd0;
            pos_reg   <= 8'd0;
            crc_reg   <= CRC_INIT;
            low_reg   <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            low_reg   <= low_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        low_next       = low_reg;
        push           = 1'b0;
        push_item.kind = OUT_PAYLOAD;
        push_item.data = 8'd0;

        case (state_reg)
            ST_HUNT:
            begin
                if (accept && in_kind == IN_RX_BYTE &&
                    byte_ext >= 9'(MIN_LEN) && byte_ext < 9'(MAX_FRAME))
                begin
                    state_next = ST_FRAME;
                    len_next   = in_byte;
                    pos_next   = 8'd1;
                    crc_next   = crc16_byte(CRC_INIT, in_byte);
                    low_next   = 8'd0;
                end
            end
            ST_FRAME:
            begin
                if (accept)
                begin
                    if (in_kind == IN_TIMEOUT)
                    begin
                        push           = 1'b1;
                        push_item.kind = OUT_ABORTED;
                        state_next     = ST_HUNT;
                        len_next       = 8'd0;
                        pos_next       = 8'd0;
                        crc_next       = CRC_INIT;
                        low_next       = 8'd0;
                    end
                    else if (pos_ext + 9'd3 <= len_ext)
                    begin
                        push           = 1'b1;
                        push_item.kind = OUT_PAYLOAD;
                        push_item.data = in_byte;
                        crc_next       = crc16_byte(crc_reg, in_byte);
                        pos_next       = pos_reg + 8'd1;
                    end
                    else if (pos_ext + 9'd2 == len_ext)
                    begin
                        low_next = in_byte;
                        pos_next = pos_reg + 8'd1;
                    end
                    else
                    begin
                        push           = 1'b1;
                        push_item.kind = ({in_byte, low_reg} == crc_reg) ? OUT_OK
                                                                          : OUT_BAD_CRC;
                        state_next     = ST_HUNT;
                        len_next       = 8'd0;
                        pos_next       = 8'd0;
                        crc_next       = CRC_INIT;
                        low_next       = 8'd0;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule

// ===== sv/lpfcrc_queue.sv =====
// queue: short fifo of result items between front and back
`timescale 1ns / 1ps

module lpfcrc_queue
    import lpfcrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lpfcrc_item_t  push_item,
    input  logic          pop,
    output lpfcrc_item_t  head_item,
    output lpfcrc_qstat_t qstat
);

    lpfcrc_item_t      entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_item   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== sv/lpfcrc_back.sv =====
// back: output register that formats queued items into result beats
`timescale 1ns / 1ps

module lpfcrc_back
    import lpfcrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  lpfcrc_qstat_t qstat,
    input  lpfcrc_item_t  head_item,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_kind,
    output logic [7:0]    out_payload,
    output logic          out_end
);

    logic       valid_reg;
    out_kind_t  kind_reg;
    logic [7:0] data_reg;

    assign pop         = !qstat.empty && (!valid_reg || out_ready);
    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_payload = data_reg;
    assign out_end     = (kind_reg != OUT_PAYLOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head_item.kind;
            data_reg <= (head_item.kind == OUT_PAYLOAD) ? head_item.data : 8'd0;
        end
    end

endmodule

// ===== sv/length_prefixed_frame_crc16_checker.sv =====
// top level: length-prefixed frame checker with crc-16/modbus
`timescale 1ns / 1ps
//
// in_ch carries one beat per received serial byte (kind 0) or idle timeout (kind 1).
// out_ch carries payload beats (out_kind 0) and one verdict beat per frame:
// ok, crc mismatch or aborted by timeout, with frame_end set.
// a length byte from 4 to 254 opens a frame; other length bytes and timeouts
// while hunting produce nothing. the crc covers the length byte and payload.
// throughput: one input beat per cycle while the queue is not full; the crc byte
// update is combinational logic in the front stage.
// an accepted result is written into the four-entry queue and then loaded into
// the output register, where it is valid.
// when the receiver stalls, the queue absorbs up to four results plus the one
// held in the output register; in_ch.ready drops only while the queue is full.
// reset (rst_n low) returns the front to hunting with crc 0xffff and empties
// the queue and output register; no clearing pass is needed.
//

module length_prefixed_frame_crc16_checker
    import lpfcrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lpfcrc_in_if.sink     in_ch,
    lpfcrc_out_if.source  out_ch
);

    lpfcrc_qstat_t qstat;
    lpfcrc_item_t  push_item;
    lpfcrc_item_t  head_item;
    logic          push;
    logic          pop;

    lpfcrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_kind   (in_ch.kind),
        .in_byte   (in_ch.rx_byte),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    lpfcrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    lpfcrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_kind    (out_ch.out_kind),
        .out_payload (out_ch.payload_byte),
        .out_end     (out_ch.frame_end)
    );

endmodule

// ===== bench/lpfcrc_result_checker.sv =====
// frame checker scoreboard: predicts every output beat from accepted input beats and compares
`timescale 1ns / 1ps

package lpfcrc_bench_pkg;

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc_in,
                                                    input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        acc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ data[i];
            acc = {1'b0, acc[15:1]};
            if (fb)
                acc = acc ^ lpfcrc_pkg::CRC_POLY;
        end
        return acc;
    endfunction

endpackage

module lpfcrc_result_checker
    import lpfcrc_pkg::*;
    import lpfcrc_bench_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    lpfcrc_in_if  in_ch,
    lpfcrc_out_if out_ch,
    output int    fail_count,
    output int    pending,
    output int    payload_count,
    output int    ok_count,
    output int    bad_count,
    output int    abort_count
);

    typedef struct packed {
        out_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    frame_beat_t expected_beats[$];

    logic        in_frame;
    logic [7:0]  frame_len;
    logic [7:0]  next_pos;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo_rx;

    task automatic enter_hunt();
        begin
            in_frame  = 1'b0;
            frame_len = 8'd0;
            next_pos  = 8'd0;
            crc_acc   = CRC_INIT;
            crc_lo_rx = 8'd0;
        end
    endtask

    task automatic predict_beat(input logic k, input logic [7:0] b);
        int unsigned pos;
        logic [15:0] rx_crc;
        begin
            pos = next_pos;
            if (!in_frame)
            begin
                if (k == IN_RX_BYTE && b >= MIN_LEN && b < MAX_FRAME)
                begin
                    in_frame  = 1'b1;
                    frame_len = b;
                    next_pos  = 8'd1;
                    crc_acc   = modbus_crc_step(CRC_INIT, b);
                    crc_lo_rx = 8'd0;
                end
            end
            else if (k == IN_TIMEOUT)
            begin
                expected_beats.push_back('{OUT_ABORTED, 8'h00, 1'b1});
                enter_hunt();
            end
            else if (pos + 3 <= frame_len)
            begin
                crc_acc  = modbus_crc_step(crc_acc, b);
                next_pos = next_pos + 8'd1;
                expected_beats.push_back('{OUT_PAYLOAD, b, 1'b0});
            end
            else if (pos + 2 == frame_len)
            begin
                crc_lo_rx = b;
                next_pos  = next_pos + 8'd1;
            end
            else
            begin
                rx_crc = {b, crc_lo_rx};
                expected_beats.push_back('{(rx_crc == crc_acc) ? OUT_OK : OUT_BAD_CRC,
                                           8'h00, 1'b1});
                enter_hunt();
            end
        end
    endtask

    task automatic check_result();
        frame_beat_t want;
        begin
            case (out_ch.out_kind)
                OUT_PAYLOAD: payload_count++;
                OUT_OK:      ok_count++;
                OUT_BAD_CRC: bad_count++;
                default:     abort_count++;
            endcase
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none actual kind %0d byte %0h end %0b",
                         $time, out_ch.out_kind, out_ch.payload_byte, out_ch.frame_end);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_ch.out_kind !== want.kind)
                begin
                    $display("%0t: out_kind mismatch, expected %0d actual %0d",
                             $time, want.kind, out_ch.out_kind);
                    fail_count++;
                end
                if (out_ch.payload_byte !== want.data)
                begin
                    $display("%0t: payload_byte mismatch, expected %0h actual %0h",
                             $time, want.data, out_ch.payload_byte);
                    fail_count++;
                end
                if (out_ch.frame_end !== want.last)
                begin
                    $display("%0t: frame_end mismatch, expected %0b actual %0b",
                             $time, want.last, out_ch.frame_end);
                    fail_count++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_hunt();
            expected_beats.delete();
            fail_count    = 0;
            payload_count = 0;
            ok_count      = 0;
            bad_count     = 0;
            abort_count   = 0;
            pending       = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_result();
            if (in_ch.valid && in_ch.ready)
                predict_beat(in_ch.kind, in_ch.rx_byte);
            pending = expected_beats.size();
        end
    end

endmodule

// ===== bench/length_prefixed_frame_crc16_checker_tb.sv =====
// testbench top: frame stimulus, idling on both channels, watchdog and verdict
`timescale 1ns / 1ps

module length_prefixed_frame_crc16_checker_tb;
    import lpfcrc_pkg::*;

    localparam int IN_BEATS     = 1800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_TIMEOUT
    } frame_shape_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    int   frame_beats;
    int   frame_no;
    int   quiet_cycles = 0;
    int   fail_count;
    int   pending;
    int   payload_count;
    int   ok_count;
    int   bad_count;
    int   abort_count;

    lpfcrc_in_if  in_ch ();
    lpfcrc_out_if out_ch ();

    length_prefixed_frame_crc16_checker u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lpfcrc_result_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .payload_count (payload_count),
        .ok_count      (ok_count),
        .bad_count     (bad_count),
        .abort_count   (abort_count)
    );

    always #6 clk = ~clk;

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog, no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // called and returns at a falling edge
    task automatic send_beat(input in_kind_t k, input logic [7:0] b);
        begin
            while (!calm && $urandom_range(0, 99) < 15)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.kind    <= k;
            in_ch.rx_byte <= b;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // fill < 0 gives random payload; cut_at 0 picks a random abort point
    task automatic send_frame(input int len, input frame_shape_t shape, input int fill,
                              input int cut_at);
        logic [15:0] crc;
        logic [15:0] sent_crc;
        logic [7:0]  b;
        int          cut;
        bit          done;
        begin
            crc      = crc16_byte(CRC_INIT, len[7:0]);
            sent_crc = 16'h0000;
            done     = 1'b0;
            if (shape != FRAME_TIMEOUT)
                cut = len;
            else if (cut_at > 0)
                cut = cut_at;
            else
                cut = $urandom_range(1, len - 1);
            send_beat(IN_RX_BYTE, len[7:0]);
            frame_beats++;
            for (int p = 1; p < len && !done; p++)
            begin
                if (p == cut)
                begin
                    b = 8'($urandom_range(0, 255));
                    send_beat(IN_TIMEOUT, b);
                    done = 1'b1;
                end
                else if (p <= len - 3)
                begin
                    if (fill < 0)
                        b = 8'($urandom_range(0, 255));
                    else
                        b = fill[7:0];
                    crc = crc16_byte(crc, b);
                    send_beat(IN_RX_BYTE, b);
                end
                else if (p == len - 2)
                begin
                    sent_crc = crc;
                    if (shape == FRAME_BAD_CRC)
                        sent_crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
                    send_beat(IN_RX_BYTE, sent_crc[7:0]);
                end
                else
                    send_beat(IN_RX_BYTE, sent_crc[15:8]);
                frame_beats++;
            end
        end
    endtask

    initial
    begin
        int           pick;
        int           len;
        int           sel;
        frame_shape_t shape;
        in_kind_t     k;
        logic [7:0]   b;

        rst_n         = 1'b0;
        calm          = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = 1'b0;
        in_ch.rx_byte = 8'h00;
        frame_beats   = 0;
        frame_no      = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // hunting: timeout and out-of-range length bytes are dropped
        send_beat(IN_TIMEOUT, 8'hFF);
        send_beat(IN_RX_BYTE, 8'd0);
        send_beat(IN_RX_BYTE, 8'd3);
        send_beat(IN_RX_BYTE, 8'd255);
        send_frame(4, FRAME_GOOD, -1, 0);
        send_frame(6, FRAME_GOOD, 8'h00, 0);
        send_frame(5, FRAME_BAD_CRC, 8'hFF, 0);
        send_frame(4, FRAME_TIMEOUT, -1, 3);
        send_frame(5, FRAME_TIMEOUT, -1, 1);

        while (frame_beats < IN_BEATS)
        begin
            calm <= (frame_beats >= 700 && frame_beats < 1000);
            pick = $urandom_range(0, 99);
            frame_no++;
            if (pick < 72)
            begin
                if (frame_no % 100 == 20)
                    len = (frame_no == 20) ? 254 : $urandom_range(150, 254);
                else
                    len = $urandom_range(4, 14);
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    shape = FRAME_GOOD;
                else if (sel < 9)
                    shape = FRAME_BAD_CRC;
                else
                    shape = FRAME_TIMEOUT;
                send_frame(len, shape, -1, 0);
            end
            else if (pick < 82)
            begin
                b = 8'($urandom_range(0, 255));
                send_beat(IN_TIMEOUT, b);
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 1) == 0)
                    b = 8'($urandom_range(0, 3));
                else
                    b = 8'd255;
                send_beat(IN_RX_BYTE, b);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    k = ($urandom_range(0, 3) == 0) ? IN_TIMEOUT : IN_RX_BYTE;
                    b = 8'($urandom_range(0, 255));
                    send_beat(k, b);
                    frame_beats++;
                end
            end
        end
        in_ch.valid <= 1'b0;
        calm        <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d frame beats over %0d stimulus picks", frame_beats, frame_no);
        $display("outputs seen: %0d payload, %0d ok, %0d crc mismatch, %0d timeout aborts",
                 payload_count, ok_count, bad_count, abort_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
